// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and codes of the positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

    // request codes
    localparam logic [2:0] REQ_INS_FIRST = 3'd0;
    localparam logic [2:0] REQ_INS_LAST  = 3'd1;
    localparam logic [2:0] REQ_INS_AT    = 3'd2;
    localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
    localparam logic [2:0] REQ_DEL_LAST  = 3'd4;
    localparam logic [2:0] REQ_DEL_AT    = 3'd5;
    localparam logic [2:0] REQ_DUMP      = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] item_value;
        logic [5:0]  position;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  element_total;
        logic [31:0] read_value;
        logic        last_flag;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic load_req;   // take the request and register its first result
        logic load_dump;  // register the next dump element
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_valid;
        logic cnt_multi;  // more than one element held
        logic dump_last;  // dump index points at the final element
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/core/positional_insert_delete_list.sv -----
// A result is registered in the cycle after its request transaction.
// Inserts and deletes take one request per cycle unless the output stalls.
// A dump of n elements gives one result per cycle when not stalled, paced by
// the single result register; input waits until its last one is registered.
// Reset clears the element count, controller state and result valid; the
// storage cells are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Bounded ordered list with positional insert, delete and dump requests.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire pidl_pkg::t_req  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output pidl_pkg::t_rsp       o_out
);
    import pidl_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    pidl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in.req_type),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pidl_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl
// Controller: input handshake and dump sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidl_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [2:0]          i_req_type,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    input  wire pidl_pkg::t_dp_sts   i_sts,
    output pidl_pkg::t_ctrl_cmd      o_cmd
);
    import pidl_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;

    assign out_free = !i_sts.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && out_free && i_req_type == REQ_DUMP && i_sts.cnt_multi) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (out_free && i_sts.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load_req  = 1'b0;
        o_cmd.load_dump = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = out_free;
                o_cmd.load_req = i_in_valid && out_free;
            end
            S_DUMP: begin
                o_cmd.load_dump = out_free;
            end
            default: ;
        endcase
    end

    // dump sequence always has a result pending in the output register
    `ASSERT_IMPL(a_dump_has_out, i_clk, i_rst_n, r_state == S_DUMP, i_sts.out_valid)
    `ASSERT_ALWAYS(a_cmd_excl, i_clk, i_rst_n, !(o_cmd.load_req && o_cmd.load_dump))

endmodule

`default_nettype wire

// ----- rtl/core/pidl_dpath.sv -----
// ----------------------------------------------------------------------------
// pidl_dpath
// Datapath: shifting storage cells, element count, dump index, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidl_dpath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pidl_pkg::t_req      i_req,
    input  wire pidl_pkg::t_ctrl_cmd i_cmd,
    input  wire logic                i_out_ready,
    output pidl_pkg::t_dp_sts        o_sts,
    output logic                     o_out_valid,
    output pidl_pkg::t_rsp           o_out
);
    import pidl_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = CW + 7;

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [IW-1:0]         r_didx;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [CMPW-1:0]       c_ext;
    logic [CMPW-1:0]       p_ext;
    logic [CMPW-1:0]       idx;
    logic                  do_ins;
    logic                  do_del;
    logic [1:0]            req_status;
    logic                  is_dump;
    logic                  dump_last;
    logic [DATA_WIDTH-1:0] ins_val;

    assign ins_val = DATA_WIDTH'(i_req.item_value);
    assign c_ext   = CMPW'(r_count);
    assign p_ext   = CMPW'(i_req.position);

    // request decode: target slot and outcome
    always_comb begin
        idx        = '0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        req_status = ST_OK;
        is_dump    = 1'b0;
        unique case (i_req.req_type) inside
            REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT: begin
                if (i_req.req_type == REQ_INS_AT &&
                    (p_ext == '0 || p_ext > c_ext + CMPW'(1))) begin
                    req_status = ST_BADPOS;
                end else if (c_ext == CMPW'(CAPACITY)) begin
                    req_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
                if (i_req.req_type == REQ_INS_LAST) begin
                    idx = c_ext;
                end else if (i_req.req_type == REQ_INS_AT) begin
                    idx = p_ext - CMPW'(1);
                end
            end
            REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT: begin
                if (r_count == '0) begin
                    req_status = ST_EMPTY;
                end else if (i_req.req_type == REQ_DEL_AT &&
                             (p_ext == '0 || p_ext > c_ext)) begin
                    req_status = ST_BADPOS;
                end else begin
                    do_del = 1'b1;
                end
                if (i_req.req_type == REQ_DEL_LAST) begin
                    idx = c_ext - CMPW'(1);
                end else if (i_req.req_type == REQ_DEL_AT) begin
                    idx = p_ext - CMPW'(1);
                end
            end
            REQ_DUMP: begin
                is_dump = 1'b1;
                if (r_count == '0) begin
                    req_status = ST_EMPTY;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.load_req && do_ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.load_req && do_del) begin
            n_count = r_count - CW'(1);
        end
    end

    // each cell takes its neighbor to open or close a gap
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam int PREV = (gi == 0) ? 0 : gi - 1;
        localparam int NEXT = (gi == CAPACITY - 1) ? gi : gi + 1;
        localparam logic [CMPW-1:0] SLOT = CMPW'(gi);
        logic [DATA_WIDTH-1:0] n_cell;

        always_comb begin
            n_cell = r_cell[gi];
            if (i_cmd.load_req && do_ins) begin
                if (SLOT == idx) begin
                    n_cell = ins_val;
                end else if (SLOT > idx) begin
                    n_cell = r_cell[PREV];
                end
            end else if (i_cmd.load_req && do_del && SLOT >= idx) begin
                n_cell = r_cell[NEXT];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[gi] <= n_cell;
        end
    end

    assign dump_last = (CW'(r_didx) == r_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_req || i_cmd.load_dump) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_didx              <= IW'(1);
            r_out.status        <= req_status;
            r_out.element_total <= 5'(n_count);
            r_out.read_value    <= (is_dump && r_count != '0) ? 32'(r_cell[0]) : 32'd0;
            r_out.last_flag     <= !(is_dump && r_count > CW'(1));
        end else if (i_cmd.load_dump) begin
            r_didx              <= r_didx + IW'(1);
            r_out.status        <= ST_OK;
            r_out.element_total <= 5'(r_count);
            r_out.read_value    <= 32'(r_cell[r_didx]);
            r_out.last_flag     <= dump_last;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_sts.cnt_multi = (r_count > CW'(1));
    assign o_sts.dump_last = dump_last;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, i_cmd.load_req || i_cmd.load_dump, r_out_valid)
    `ASSERT_NEXT(a_dump_cnt_hold, i_clk, i_rst_n, i_cmd.load_dump, $stable(r_count))

endmodule

`default_nettype wire
